[rtl/cfct_pkg.sv]
package cfct_pkg;

  localparam int CoordW    = 22;
  localparam int RadW      = 21;
  localparam int WeightW   = 16;
  localparam int CostW     = 64;
  localparam int CountW    = 17;
  localparam int DiffW     = CoordW + 1;
  localparam int D2W       = 2 * DiffW;
  localparam int RootSteps = DiffW;
  localparam int SqW       = 2 * RadW;
  localparam int TermW     = SqW + WeightW - 8 + 1;
  localparam int IndexW    = 3;

  localparam logic [RadW-1:0] CUT_RESET = RadW'(200 * 256);

  typedef enum logic [IndexW-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_RESIDUAL_CUT = 3'd3,
    REG_COST_KIND    = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_SQUARE   = 2'd0,
    KIND_WEIGHTED = 2'd1,
    KIND_COUNT    = 2'd2,
    KIND_NONE     = 2'd3
  } cost_kind_t;

  // word handed from one root cell to the next
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [WeightW-1:0] weight;
    logic [D2W-1:0]     rem;
    logic [D2W-1:0]     root;
  } sqrt_word_t;

  // word handed to the accumulator
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    inlier;
    logic signed [TermW-1:0] term;
  } acc_word_t;

endpackage

[rtl/cfct_sqrt_cell.sv]
module cfct_sqrt_cell import cfct_pkg::*; #(
  parameter int Step = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  sqrt_word_t d,
  output sqrt_word_t q
);

  localparam int BitPos = 2 * (RootSteps - 1 - Step);
  localparam logic [D2W-1:0] TrialBit = D2W'(1) << BitPos;

  logic [D2W:0] trial;
  logic         fits;
  sqrt_word_t   q_next;

  assign trial = {1'b0, d.root} + {1'b0, TrialBit};
  assign fits  = {1'b0, d.rem} >= trial;

  always_comb begin
    q_next = d;
    if (fits) begin
      q_next.rem  = d.rem - trial[D2W-1:0];
      q_next.root = (d.root >> 1) + TrialBit;
    end else begin
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (advance) begin
      q <= q_next;
    end
  end

endmodule

[rtl/cfct_accum.sv]
module cfct_accum import cfct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_word_t               d,
  output logic                    hold,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CostW-1:0] cost,
  output logic [CountW-1:0]       inlier_count
);

  localparam logic signed [CostW-1:0] CostMax = {1'b0, {(CostW-1){1'b1}}};
  localparam logic signed [CostW-1:0] CostMin = {1'b1, {(CostW-1){1'b0}}};

  logic signed [CostW-1:0] cost_sum;
  logic [CountW-1:0]       inlier_total;
  logic [CostW:0]          wide_sum;
  logic signed [CostW-1:0] cost_sum_next;
  logic [CountW-1:0]       inlier_total_next;
  logic                    take;

  // a finished set waits while the output word is still unclaimed
  assign hold = d.valid && d.last && out_valid && !out_ready;
  assign take = d.valid && !hold;

  assign wide_sum = {cost_sum[CostW-1], cost_sum}
                  + {{(CostW+1-TermW){d.term[TermW-1]}}, d.term};

  always_comb begin
    if (wide_sum[CostW] != wide_sum[CostW-1]) begin
      cost_sum_next = wide_sum[CostW] ? CostMin : CostMax;
    end else begin
      cost_sum_next = wide_sum[CostW-1:0];
    end
    if (d.inlier && (inlier_total != {CountW{1'b1}})) begin
      inlier_total_next = inlier_total + 1'b1;
    end else begin
      inlier_total_next = inlier_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum     <= '0;
      inlier_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (d.last) begin
          out_valid    <= 1'b1;
          cost         <= cost_sum_next;
          inlier_count <= inlier_total_next;
          cost_sum     <= '0;
          inlier_total <= '0;
        end else begin
          cost_sum     <= cost_sum_next;
          inlier_total <= inlier_total_next;
        end
      end
    end
  end

  a_set_loads_output: assert property (@(posedge clk) disable iff (rst)
    d.valid && d.last && !hold |=> out_valid)
    else $error("finished set did not load the output word");

  a_set_clears_totals: assert property (@(posedge clk) disable iff (rst)
    d.valid && d.last && !hold |=> cost_sum == '0 && inlier_total == '0)
    else $error("totals not cleared after a finished set");

  a_outlier_keeps_count: assert property (@(posedge clk) disable iff (rst)
    d.valid && !d.last && !d.inlier && !hold |=> $stable(inlier_total))
    else $error("inlier count moved on an outlier");

endmodule

[rtl/circle_fit_truncated_cost.sv]
// Truncated least-squares cost of a candidate circle over a stream of hit points.
// Configuration: write center_x, center_y, radius, residual_cut and cost_kind
// through cfg_write / cfg_index / cfg_data while no set is in progress.
// Input channel (in_valid / in_ready): one word per hit point; last_point closes
// a set. Output channel (out_valid / out_ready): one word per set, carrying the
// saturated cost and the inlier count, both including the last point.
// Throughput: one point per cycle while the row is not held (see Stall). The
// distance root is a row of 23 cells, one result bit each, so a point passes 3
// front stages, 23 root cells, 3 residual and cost stages and the accumulator
// before the set's word shows.
// Stall: when a last point reaches the accumulator while the previous set's word
// is still unclaimed, the whole row holds and in_ready drops until out_ready.
// Reset: registers return to their defaults (cut 200 mm, all else zero), the
// totals clear and all words in flight are dropped.
module circle_fit_truncated_cost import cfct_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [IndexW-1:0]        cfg_index,
  input  logic [CoordW-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] point_x,
  input  logic signed [CoordW-1:0] point_y,
  input  logic [WeightW-1:0]       weight,
  input  logic                     last_point,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CostW-1:0]  cost,
  output logic [CountW-1:0]        inlier_count
);

  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic [RadW-1:0]          radius;
  logic [RadW-1:0]          residual_cut;
  logic [1:0]               cost_kind;

  logic advance;
  logic hold;

  assign advance  = !hold;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius       <= '0;
      residual_cut <= CUT_RESET;
      cost_kind    <= KIND_SQUARE;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_RADIUS:       radius       <= cfg_data[RadW-1:0];
        REG_RESIDUAL_CUT: residual_cut <= cfg_data[RadW-1:0];
        REG_COST_KIND:    cost_kind    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // offset from the center
  logic                    s1_valid;
  logic                    s1_last;
  logic [WeightW-1:0]      s1_weight;
  logic signed [DiffW-1:0] s1_u;
  logic signed [DiffW-1:0] s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s1_last   <= last_point;
      s1_weight <= weight;
      s1_u      <= {point_x[CoordW-1], point_x} - {center_x[CoordW-1], center_x};
      s1_v      <= {point_y[CoordW-1], point_y} - {center_y[CoordW-1], center_y};
    end
  end

  // squares
  logic signed [D2W-1:0] u_sq;
  logic signed [D2W-1:0] v_sq;
  logic                  s2_valid;
  logic                  s2_last;
  logic [WeightW-1:0]    s2_weight;
  logic [D2W-1:0]        s2_u2;
  logic [D2W-1:0]        s2_v2;

  assign u_sq = s1_u * s1_u;
  assign v_sq = s1_v * s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid  <= s1_valid;
      s2_last   <= s1_last;
      s2_weight <= s1_weight;
      s2_u2     <= unsigned'(u_sq);
      s2_v2     <= unsigned'(v_sq);
    end
  end

  // squared distance enters the root row
  sqrt_word_t chain [RootSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (advance) begin
      chain[0].valid  <= s2_valid;
      chain[0].last   <= s2_last;
      chain[0].weight <= s2_weight;
      chain[0].rem    <= s2_u2 + s2_v2;
      chain[0].root   <= '0;
    end
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    cfct_sqrt_cell #(.Step(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .d       (chain[k]),
      .q       (chain[k+1])
    );
  end

  // residual and cut
  logic [RootSteps-1:0] root_dist;
  logic [DiffW:0]       res;
  logic [DiffW:0]       ares;
  logic                 sa_valid;
  logic                 sa_last;
  logic                 sa_inlier;
  logic [WeightW-1:0]   sa_weight;
  logic [RadW-1:0]      sa_ares;

  assign root_dist = chain[RootSteps].root[RootSteps-1:0];
  assign res  = {(DiffW + 1 - RadW)'(0), radius} - {1'b0, root_dist};
  assign ares = res[DiffW] ? (~res + 1'b1) : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (advance) begin
      sa_valid  <= chain[RootSteps].valid;
      sa_last   <= chain[RootSteps].last;
      sa_weight <= chain[RootSteps].weight;
      sa_inlier <= ares < {(DiffW + 1 - RadW)'(0), residual_cut};
      sa_ares   <= ares[RadW-1:0];
    end
  end

  // squared residual
  logic [SqW-1:0]     sq;
  logic               sb_valid;
  logic               sb_last;
  logic               sb_inlier;
  logic [WeightW-1:0] sb_weight;
  logic [SqW-1:0]     sb_sq;

  assign sq = sa_ares * sa_ares;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (advance) begin
      sb_valid  <= sa_valid;
      sb_last   <= sa_last;
      sb_inlier <= sa_inlier;
      sb_weight <= sa_weight;
      sb_sq     <= sq;
    end
  end

  // term to add for this point
  logic [SqW+WeightW-1:0]  weighted;
  logic signed [TermW-1:0] term;
  acc_word_t               sc;

  assign weighted = sb_sq * sb_weight;

  always_comb begin
    term = '0;
    if (sb_inlier) begin
      unique case (cost_kind_t'(cost_kind))
        KIND_SQUARE:   term = {(TermW - SqW)'(0), sb_sq};
        KIND_WEIGHTED: term = {1'b0, weighted[SqW+WeightW-1:8]};
        KIND_COUNT:    term = '1;
        KIND_NONE:     term = '0;
        default:       term = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc.valid <= 1'b0;
    end else if (advance) begin
      sc.valid  <= sb_valid;
      sc.last   <= sb_last;
      sc.inlier <= sb_inlier;
      sc.term   <= term;
    end
  end

  cfct_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .d            (sc),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cost         (cost),
    .inlier_count (inlier_count)
  );

endmodule
